// ----- hdl/jdg_pkg.sv -----
`timescale 1ns / 1ps
package jdg_pkg;

  // Default grid limits.
  localparam int MAX_ROWS_DEF    = 64;
  localparam int MAX_COLUMNS_DEF = 64;

  // Widths fixed by the item and register formats.
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 7;
  localparam int OP_W    = 2;
  localparam int STEP_W  = 16;
  localparam int CELL_W  = 6;
  localparam int CIDX_W  = 3;
  localparam int ACC_W   = WORD_W + 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INIT    = 2'd0;
  localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ    = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_ROWS   = 3'd0;
  localparam logic [CIDX_W-1:0] REG_COLS   = 3'd1;
  localparam logic [CIDX_W-1:0] REG_TOP    = 3'd2;
  localparam logic [CIDX_W-1:0] REG_BOTTOM = 3'd3;
  localparam logic [CIDX_W-1:0] REG_LEFT   = 3'd4;
  localparam logic [CIDX_W-1:0] REG_RIGHT  = 3'd5;
  localparam logic [CIDX_W-1:0] REG_MIDDLE = 3'd6;

  // Register reset values.
  localparam logic [COUNT_W-1:0] ROWS_RST = 7'd10;
  localparam logic [COUNT_W-1:0] COLS_RST = 7'd10;
  localparam logic [WORD_W-1:0]  TOP_RST  = 32'h0064_0000;

endpackage

// ----- hdl/jdg_bank_mem.sv -----
`timescale 1ns / 1ps
// One grid bank: single write port, single read port, registered read data.
module jdg_bank_mem #(
  parameter int AW = 12
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [jdg_pkg::WORD_W-1:0] wr_data,
  input  logic [AW-1:0]              rd_addr,
  output logic [jdg_pkg::WORD_W-1:0] rd_data
);

  logic [jdg_pkg::WORD_W-1:0] mem [0:(2**AW)-1];
  logic [jdg_pkg::WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/jacobi_diffusion_grid.sv -----
`timescale 1ns / 1ps
// Jacobi diffusion grid.
// Input channel (in_valid/in_stall) takes one command item: init, advance or
// read. Result channel (out_valid/out_stall) returns exactly one item per
// command: the echoed opcode and, for a read, the cell value (zero otherwise).
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data) and is
// to be written only while the block is idle.
// Work per item, from acceptance to result:
//   init: one cell written per cycle.
//   advance: each cell takes four reads of the
//   single read port of the source bank plus accumulate and write-back.
//   read: one registered memory read; an out-of-range read, an unused
//   opcode or a zero-step advance answers in the next cycle.
// One item is worked at a time; the next is accepted once the result slot is
// free or being taken. A stalled result holds and blocks the next item.
// Reset restores the register defaults and empties the result slot; grid
// contents are undefined until an init.
module jacobi_diffusion_grid #(
  parameter int MAX_ROWS    = jdg_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = jdg_pkg::MAX_COLUMNS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [jdg_pkg::OP_W-1:0]    in_opcode,
  input  logic [jdg_pkg::STEP_W-1:0]  in_step_count,
  input  logic [jdg_pkg::CELL_W-1:0]  in_cell_row,
  input  logic [jdg_pkg::CELL_W-1:0]  in_cell_column,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [jdg_pkg::OP_W-1:0]    out_op_done,
  output logic signed [jdg_pkg::WORD_W-1:0] out_cell_value,
  input  logic                        cfg_wr_en,
  input  logic [jdg_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [jdg_pkg::WORD_W-1:0]  cfg_data
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int AW = RW + CW;
  localparam int WW = jdg_pkg::WORD_W;
  localparam int AC = jdg_pkg::ACC_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_INIT = 4'b0010,
    ST_STEP = 4'b0100,
    ST_RDW  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [jdg_pkg::COUNT_W-1:0] rows_cfg_r, cols_cfg_r;
  logic [WW-1:0] top_r, bottom_r, left_r, right_r, middle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= jdg_pkg::ROWS_RST;
      cols_cfg_r <= jdg_pkg::COLS_RST;
      top_r      <= jdg_pkg::TOP_RST;
      bottom_r   <= '0;
      left_r     <= '0;
      right_r    <= '0;
      middle_r   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        jdg_pkg::REG_ROWS:   rows_cfg_r <= cfg_data[jdg_pkg::COUNT_W-1:0];
        jdg_pkg::REG_COLS:   cols_cfg_r <= cfg_data[jdg_pkg::COUNT_W-1:0];
        jdg_pkg::REG_TOP:    top_r      <= cfg_data;
        jdg_pkg::REG_BOTTOM: bottom_r   <= cfg_data;
        jdg_pkg::REG_LEFT:   left_r     <= cfg_data;
        jdg_pkg::REG_RIGHT:  right_r    <= cfg_data;
        jdg_pkg::REG_MIDDLE: middle_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Last interior row and column in use, after clamping the counts.
  logic [RW-1:0] last_row;
  logic [CW-1:0] last_col;

  always_comb begin
    if (rows_cfg_r == '0) begin
      last_row = '0;
    end else if (32'(rows_cfg_r) > MAX_ROWS) begin
      last_row = RW'(MAX_ROWS - 1);
    end else begin
      last_row = RW'(rows_cfg_r - 7'd1);
    end
    if (cols_cfg_r == '0) begin
      last_col = '0;
    end else if (32'(cols_cfg_r) > MAX_COLUMNS) begin
      last_col = CW'(MAX_COLUMNS - 1);
    end else begin
      last_col = CW'(cols_cfg_r - 7'd1);
    end
  end

  // Sweep state.
  logic [RW-1:0]  row_r, row_nxt;
  logic [CW-1:0]  col_r, col_nxt;
  logic [2:0]     phase_r, phase_nxt;
  logic [jdg_pkg::STEP_W-1:0] steps_r, steps_nxt;
  logic           cur_r, cur_nxt;
  logic signed [AC-1:0] acc_r, acc_nxt;

  // Result slot.
  logic                  out_valid_r, out_valid_nxt;
  logic [jdg_pkg::OP_W-1:0] out_op_r, out_op_nxt;
  logic [WW-1:0]         out_val_r, out_val_nxt;

  // Memory ports.
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [WW-1:0] wdata, rd0, rd1, rdata;

  logic in_acc, row_last, col_last, rd_in_range;
  logic [WW-1:0] nb;
  logic signed [AC-1:0] qsum;

  assign in_stall   = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_acc     = in_valid && !in_stall;
  assign rdata      = cur_r ? rd1 : rd0;
  assign row_last   = (row_r == last_row);
  assign col_last   = (col_r == last_col);
  assign rd_in_range = (32'(in_cell_row) <= 32'(last_row)) &&
                       (32'(in_cell_column) <= 32'(last_col));

  // Neighbour value for the phase whose read data is arriving now.
  always_comb begin
    case (phase_r)
      3'd1:    nb = (row_r == '0) ? top_r : rdata;
      3'd2:    nb = row_last ? bottom_r : rdata;
      3'd3:    nb = (col_r == '0) ? left_r : rdata;
      3'd4:    nb = col_last ? right_r : rdata;
      default: nb = '0;
    endcase
  end

  // Quarter of the sum, truncated toward zero.
  assign qsum = acc_r[AC-1] ? (acc_r + AC'(3)) : acc_r;

  // Read address: command read in idle, the four neighbours during a sweep.
  always_comb begin
    raddr = '0;
    case (state_r)
      ST_IDLE: raddr = {RW'(in_cell_row), CW'(in_cell_column)};
      ST_STEP: begin
        case (phase_r)
          3'd0:    raddr = {row_r - RW'(1), col_r};
          3'd1:    raddr = {row_r + RW'(1), col_r};
          3'd2:    raddr = {row_r, col_r - CW'(1)};
          3'd3:    raddr = {row_r, col_r + CW'(1)};
          default: raddr = {row_r, col_r};
        endcase
      end
      default: raddr = '0;
    endcase
  end

  // Control.
  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    phase_nxt     = phase_r;
    steps_nxt     = steps_r;
    cur_nxt       = cur_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_op_nxt    = out_op_r;
    out_val_nxt   = out_val_r;
    we            = 1'b0;
    waddr         = {row_r, col_r};
    wdata         = middle_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          out_op_nxt  = in_opcode;
          out_val_nxt = '0;
          row_nxt     = '0;
          col_nxt     = '0;
          phase_nxt   = '0;
          acc_nxt     = '0;
          steps_nxt   = in_step_count;
          case (in_opcode)
            jdg_pkg::OP_INIT: state_nxt = ST_INIT;
            jdg_pkg::OP_ADVANCE: begin
              if (in_step_count == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = ST_STEP;
              end
            end
            jdg_pkg::OP_READ: begin
              if (rd_in_range) begin
                state_nxt = ST_RDW;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      ST_INIT: begin
        we = 1'b1;
        if (col_last) begin
          col_nxt = '0;
          if (row_last) begin
            row_nxt       = '0;
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
          end else begin
            row_nxt = row_r + RW'(1);
          end
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end
      ST_STEP: begin
        if (phase_r == 3'd5) begin
          we        = 1'b1;
          wdata     = qsum[AC-1:2];
          phase_nxt = '0;
          acc_nxt   = '0;
          if (col_last) begin
            col_nxt = '0;
            if (row_last) begin
              row_nxt   = '0;
              cur_nxt   = !cur_r;
              steps_nxt = steps_r - 16'd1;
              if (steps_r == 16'd1) begin
                state_nxt     = ST_IDLE;
                out_valid_nxt = 1'b1;
              end
            end else begin
              row_nxt = row_r + RW'(1);
            end
          end else begin
            col_nxt = col_r + CW'(1);
          end
        end else begin
          phase_nxt = phase_r + 3'd1;
          acc_nxt   = acc_r + AC'(signed'(nb));
        end
      end
      ST_RDW: begin
        out_val_nxt   = rdata;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cur_r       <= 1'b0;
      phase_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cur_r       <= cur_nxt;
      phase_r     <= phase_nxt;
    end
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    steps_r   <= steps_nxt;
    acc_r     <= acc_nxt;
    out_op_r  <= out_op_nxt;
    out_val_r <= out_val_nxt;
  end

  // Init writes the current bank; a sweep writes the other one.
  logic wbank;
  assign wbank = (state_r == ST_INIT) ? cur_r : !cur_r;

  jdg_bank_mem #(.AW(AW)) u_bank0 (
    .clk     (clk),
    .wr_en   (we && !wbank),
    .wr_addr (waddr),
    .wr_data (wdata),
    .rd_addr (raddr),
    .rd_data (rd0)
  );

  jdg_bank_mem #(.AW(AW)) u_bank1 (
    .clk     (clk),
    .wr_en   (we && wbank),
    .wr_addr (waddr),
    .wr_data (wdata),
    .rd_addr (raddr),
    .rd_data (rd1)
  );

  assign out_valid      = out_valid_r;
  assign out_op_done    = out_op_r;
  assign out_cell_value = out_val_r;

endmodule

// ----- hdl/jdg_checker.sv -----
`timescale 1ns / 1ps
module jdg_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [jdg_pkg::OP_W-1:0]    in_opcode,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [jdg_pkg::OP_W-1:0]    out_op_done,
  input logic [jdg_pkg::WORD_W-1:0]  out_cell_value
);

  // Reset empties the result slot.
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // A stalled result holds its contents.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_op_done) &&
    $stable(out_cell_value))
    else $error("stalled result changed");

  // No new item is taken while a result is blocked.
  a_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("item accepted while result blocked");

  // An unused opcode answers at once with a zero value.
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_opcode == jdg_pkg::OP_NONE |=>
    out_valid && out_op_done == jdg_pkg::OP_NONE && out_cell_value == '0)
    else $error("unused opcode answered wrongly");

endmodule

bind jacobi_diffusion_grid jdg_checker u_jdg_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_opcode      (in_opcode),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_op_done    (out_op_done),
  .out_cell_value (out_cell_value)
);

// ----- tb/sv/jacobi_diffusion_grid_test.sv -----
`timescale 1ns / 1ps
module jacobi_diffusion_grid_test;

  localparam int GRID_DIM = 64;
  localparam longint CYCLE_LIMIT = 20000000;

  typedef struct packed {
    logic [jdg_pkg::OP_W-1:0]   op;
    logic [jdg_pkg::WORD_W-1:0] value;
  } grid_reply_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  logic [jdg_pkg::OP_W-1:0]         in_opcode;
  logic [jdg_pkg::STEP_W-1:0]       in_step_count;
  logic [jdg_pkg::CELL_W-1:0]       in_cell_row;
  logic [jdg_pkg::CELL_W-1:0]       in_cell_column;
  logic                             out_valid;
  logic                             out_stall;
  logic [jdg_pkg::OP_W-1:0]         out_op_done;
  logic signed [jdg_pkg::WORD_W-1:0] out_cell_value;
  logic                             cfg_wr_en;
  logic [jdg_pkg::CIDX_W-1:0]       cfg_index;
  logic [jdg_pkg::WORD_W-1:0]       cfg_data;

  // Shadow copy of the block's registers and grid.
  logic [jdg_pkg::COUNT_W-1:0] rows_reg, cols_reg;
  logic [jdg_pkg::WORD_W-1:0]  top_reg, bottom_reg, left_reg, right_reg, middle_reg;
  logic [jdg_pkg::WORD_W-1:0]  grid_now [GRID_DIM*GRID_DIM];
  logic [jdg_pkg::WORD_W-1:0]  grid_next [GRID_DIM*GRID_DIM];

  grid_reply_t pending_replies[$];
  int     mismatch_count;
  longint cycle_count;
  int     send_idle_pct;
  int     recv_stall_pct;
  int     hold_cycles;

  jacobi_diffusion_grid dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_step_count(in_step_count),
    .in_cell_row(in_cell_row), .in_cell_column(in_cell_column),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_op_done(out_op_done), .out_cell_value(out_cell_value),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // A count of zero behaves as one, anything above the grid size as the maximum.
  function automatic int span_of(logic [jdg_pkg::COUNT_W-1:0] cnt);
    if (cnt == 0) return 1;
    if (cnt > GRID_DIM) return GRID_DIM;
    return int'(cnt);
  endfunction

  // One Jacobi sweep: quarter of the four neighbour sum, truncated toward zero.
  function automatic void sweep_grid(int rows, int cols);
    longint up, dn, lf, rt, total;
    int here;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        here = r * GRID_DIM + c;
        up = (r == 0) ? longint'($signed(top_reg)) : longint'($signed(grid_now[here-GRID_DIM]));
        dn = (r == rows - 1) ? longint'($signed(bottom_reg))
                             : longint'($signed(grid_now[here+GRID_DIM]));
        lf = (c == 0) ? longint'($signed(left_reg)) : longint'($signed(grid_now[here-1]));
        rt = (c == cols - 1) ? longint'($signed(right_reg)) : longint'($signed(grid_now[here+1]));
        total = (up + lf + rt + dn) / 4;
        grid_next[here] = total[jdg_pkg::WORD_W-1:0];
      end
    end
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < cols; c++)
        grid_now[r*GRID_DIM+c] = grid_next[r*GRID_DIM+c];
  endfunction

  // Applies one command to the shadow grid and returns the reply it should give.
  function automatic grid_reply_t apply_command(logic [jdg_pkg::OP_W-1:0] op,
                                                logic [jdg_pkg::STEP_W-1:0] steps,
                                                logic [jdg_pkg::CELL_W-1:0] row,
                                                logic [jdg_pkg::CELL_W-1:0] col);
    grid_reply_t reply;
    int rows, cols;
    rows = span_of(rows_reg);
    cols = span_of(cols_reg);
    reply.op = op;
    reply.value = '0;
    case (op)
      jdg_pkg::OP_INIT: begin
        for (int r = 0; r < rows; r++)
          for (int c = 0; c < cols; c++)
            grid_now[r*GRID_DIM+c] = middle_reg;
      end
      jdg_pkg::OP_ADVANCE: begin
        for (int t = 0; t < int'(steps); t++) sweep_grid(rows, cols);
      end
      jdg_pkg::OP_READ: begin
        if (int'(row) < rows && int'(col) < cols) reply.value = grid_now[row*GRID_DIM+col];
      end
      default: ;
    endcase
    return reply;
  endfunction

  // Register write, shadowed at once; only called while the block is idle.
  task automatic write_reg(logic [jdg_pkg::CIDX_W-1:0] idx, logic [jdg_pkg::WORD_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      jdg_pkg::REG_ROWS:   rows_reg   = data[jdg_pkg::COUNT_W-1:0];
      jdg_pkg::REG_COLS:   cols_reg   = data[jdg_pkg::COUNT_W-1:0];
      jdg_pkg::REG_TOP:    top_reg    = data;
      jdg_pkg::REG_BOTTOM: bottom_reg = data;
      jdg_pkg::REG_LEFT:   left_reg   = data;
      jdg_pkg::REG_RIGHT:  right_reg  = data;
      jdg_pkg::REG_MIDDLE: middle_reg = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_grid(int rows, int cols, logic [jdg_pkg::WORD_W-1:0] top,
                          logic [jdg_pkg::WORD_W-1:0] bottom, logic [jdg_pkg::WORD_W-1:0] lf,
                          logic [jdg_pkg::WORD_W-1:0] rt, logic [jdg_pkg::WORD_W-1:0] mid);
    write_reg(jdg_pkg::REG_ROWS, jdg_pkg::WORD_W'(rows));
    write_reg(jdg_pkg::REG_COLS, jdg_pkg::WORD_W'(cols));
    write_reg(jdg_pkg::REG_TOP, top);
    write_reg(jdg_pkg::REG_BOTTOM, bottom);
    write_reg(jdg_pkg::REG_LEFT, lf);
    write_reg(jdg_pkg::REG_RIGHT, rt);
    write_reg(jdg_pkg::REG_MIDDLE, mid);
  endtask

  // Offers one item, with an occasional gap first, and waits for acceptance.
  task automatic send_command(logic [jdg_pkg::OP_W-1:0] op, logic [jdg_pkg::STEP_W-1:0] steps,
                              logic [jdg_pkg::CELL_W-1:0] row, logic [jdg_pkg::CELL_W-1:0] col);
    int gap;
    @(negedge clk);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_step_count  <= steps;
    in_cell_row    <= row;
    in_cell_column <= col;
    do @(posedge clk); while (in_stall);
    pending_replies.push_back(apply_command(op, steps, row, col));
  endtask

  // Lowers valid and waits until every reply has come back.
  task automatic drain_replies();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Random item; reads mostly land inside the grid in use.
  task automatic send_random_command();
    int pick;
    logic [jdg_pkg::STEP_W-1:0] steps;
    logic [jdg_pkg::CELL_W-1:0] row, col;
    pick = $urandom_range(0, 99);
    steps = ($urandom_range(0, 9) == 0) ? jdg_pkg::STEP_W'($urandom_range(10, 40))
                                        : jdg_pkg::STEP_W'($urandom_range(0, 6));
    if ($urandom_range(0, 9) < 7) begin
      row = jdg_pkg::CELL_W'($urandom_range(0, span_of(rows_reg) - 1));
      col = jdg_pkg::CELL_W'($urandom_range(0, span_of(cols_reg) - 1));
    end else begin
      row = jdg_pkg::CELL_W'($urandom);
      col = jdg_pkg::CELL_W'($urandom);
    end
    if (pick < 10)      send_command(jdg_pkg::OP_INIT, jdg_pkg::STEP_W'($urandom), row, col);
    else if (pick < 35) send_command(jdg_pkg::OP_ADVANCE, steps, row, col);
    else if (pick < 88) send_command(jdg_pkg::OP_READ, jdg_pkg::STEP_W'($urandom), row, col);
    else                send_command(jdg_pkg::OP_NONE, jdg_pkg::STEP_W'($urandom), row, col);
  endtask

  // Register defaults, every opcode, out-of-range reads and a zero-step advance.
  task automatic test_defaults();
    send_command(jdg_pkg::OP_READ, '0, 6'd63, 6'd63);
    send_command(jdg_pkg::OP_INIT, '0, '0, '0);
    send_command(jdg_pkg::OP_ADVANCE, 16'd3, '0, '0);
    send_command(jdg_pkg::OP_READ, '0, 6'd0, 6'd0);
    send_command(jdg_pkg::OP_READ, '0, 6'd9, 6'd9);
    send_command(jdg_pkg::OP_READ, '0, 6'd10, 6'd0);
    send_command(jdg_pkg::OP_READ, '0, 6'd0, 6'd10);
    send_command(jdg_pkg::OP_ADVANCE, 16'd0, '0, '0);
    send_command(jdg_pkg::OP_NONE, 16'hFFFF, 6'd63, 6'd63);
    send_command(jdg_pkg::OP_READ, '0, 6'd1, 6'd5);
    drain_replies();
  endtask

  // Counts of zero and above the maximum, extreme edge values, the longest advance.
  task automatic test_extremes();
    set_grid(0, 127, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_command(jdg_pkg::OP_INIT, '0, '0, '0);
    send_command(jdg_pkg::OP_ADVANCE, 16'd2, '0, '0);
    send_command(jdg_pkg::OP_READ, '0, 6'd0, 6'd63);
    send_command(jdg_pkg::OP_READ, '0, 6'd1, 6'd0);
    drain_replies();
    set_grid(1, 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFF);
    send_command(jdg_pkg::OP_INIT, '0, '0, '0);
    send_command(jdg_pkg::OP_READ, '0, 6'd0, 6'd0);
    send_command(jdg_pkg::OP_ADVANCE, 16'hFFFF, '0, '0);
    send_command(jdg_pkg::OP_READ, '0, 6'd0, 6'd0);
    drain_replies();
    set_grid(64, 64, 32'hFFFF_0000, 32'h0001_0003, 32'h0000_0001, 32'hFFFF_FFFD, 32'h1234_5678);
    send_command(jdg_pkg::OP_INIT, '0, '0, '0);
    send_command(jdg_pkg::OP_ADVANCE, 16'd1, '0, '0);
    send_command(jdg_pkg::OP_READ, '0, 6'd63, 6'd63);
    send_command(jdg_pkg::OP_READ, '0, 6'd0, 6'd31);
    drain_replies();
  endtask

  // Edge values changed between init and advance take effect at once.
  task automatic test_live_edges();
    set_grid(3, 4, 32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 32'h0004_0000, 32'h0000_8000);
    send_command(jdg_pkg::OP_INIT, '0, '0, '0);
    drain_replies();
    write_reg(jdg_pkg::REG_RIGHT, 32'h0100_0000);
    write_reg(jdg_pkg::REG_TOP, 32'hFF00_0007);
    send_command(jdg_pkg::OP_ADVANCE, 16'd2, '0, '0);
    send_command(jdg_pkg::OP_READ, '0, 6'd0, 6'd3);
    send_command(jdg_pkg::OP_READ, '0, 6'd2, 6'd0);
    drain_replies();
  endtask

  // A random grid setting with an init first, then random items.
  task automatic test_random_phase(int idle_pct, int stall_pct, int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    set_grid($urandom_range(1, 8), $urandom_range(1, 8), $urandom, $urandom, $urandom,
             $urandom, $urandom);
    send_command(jdg_pkg::OP_INIT, '0, '0, '0);
    repeat (count) send_random_command();
    drain_replies();
  endtask

  // The receiver holds off while items keep coming, then the sender waits for all replies.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 300;
    repeat (6) send_random_command();
    drain_replies();
    repeat (4) send_random_command();
    drain_replies();
  endtask

  // Receiver stall, either random or a counted hold-off.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Compares each reply with the oldest expectation.
  always @(posedge clk) begin
    grid_reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected reply: op %0d value %h", out_op_done, out_cell_value);
      end else begin
        want = pending_replies.pop_front();
        if (out_op_done !== want.op || out_cell_value !== want.value) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("reply mismatch: expected op %0d value %h, got op %0d value %h",
                     want.op, want.value, out_op_done, out_cell_value);
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("jacobi_diffusion_grid_test: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = '0;
    in_step_count = '0;
    in_cell_row = '0;
    in_cell_column = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatch_count = 0;
    cycle_count = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rows_reg = jdg_pkg::ROWS_RST;
    cols_reg = jdg_pkg::COLS_RST;
    top_reg = jdg_pkg::TOP_RST;
    bottom_reg = '0;
    left_reg = '0;
    right_reg = '0;
    middle_reg = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    test_defaults();
    test_extremes();
    test_live_edges();
    test_random_phase(8, 83, 35);
    test_random_phase(83, 8, 35);
    test_random_phase(0, 0, 35);
    test_backpressure();

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("jacobi_diffusion_grid_test: done, clean");
    end else begin
      $display("jacobi_diffusion_grid_test: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/jdg_pkg.sv
hdl/jdg_bank_mem.sv
hdl/jacobi_diffusion_grid.sv
hdl/jdg_checker.sv
tb/sv/jacobi_diffusion_grid_test.sv
